>>> rtl/grhsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv_pkg
// Shared types, constants and helpers of the golden-ratio HSV color generator.
// ----------------------------------------------------------------------------
package grhsv_pkg;

   localparam int CHAN_BITS     = 8;
   localparam int HUE_OUT_BITS  = 16;
   localparam int SEED_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Fractional part of the golden ratio, 64 bits; the step is its top bits.
   localparam logic [63:0] GOLD_FRAC64 = 64'h9E37_79B9_7F4A_7C15;

   // Channel = round(255 * 0.95 * (1 - S * x)) reduces to
   //   floor((9710 * 2^H - 969 * 10S * x) / 2^(H+3)) / 5
   localparam int          MUL_BITS     = 14;
   localparam logic [13:0] SAT_MUL_LITE = 14'd4845;  // 969 * 5
   localparam logic [13:0] SAT_MUL_DARK = 14'd8721;  // 969 * 9
   localparam logic [13:0] NUM_BIAS     = 14'd9710;  // 969 * 10 + rounding half
   localparam int          Y_BITS       = 11;        // quotient before /5, max 1213

   // floor(y / 5) as (y * 1639) >> 13, exact for y < 2730
   localparam logic [10:0] RECIP_FIVE   = 11'd1639;
   localparam int          RECIP_SHIFT  = 13;
   localparam int          RECIP_BITS   = 22;

   // Channels that do not depend on the sector position
   localparam logic [7:0] CHAN_V      = 8'd242;  // value
   localparam logic [7:0] CHAN_P_LITE = 8'd121;  // p, saturation 0.5
   localparam logic [7:0] CHAN_P_DARK = 8'd24;   // p, saturation 0.9

   typedef enum logic [0:0] {
      REG_HUE_SEED = 1'b0
   } reg_index_type;

   typedef enum logic [2:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } hue_sector_type;

   // Payload between the sector stage and the scale stage
   typedef struct packed {
      logic                    dark;
      hue_sector_type          sector;
      logic [Y_BITS-1:0]       y_q;
      logic [Y_BITS-1:0]       y_t;
      logic [HUE_OUT_BITS-1:0] hue_out;
   } mid_stage_type;

   function automatic logic [CHAN_BITS-1:0] scale_chan(input logic [Y_BITS-1:0] y);
      logic [RECIP_BITS-1:0] prod;
      prod = RECIP_BITS'(y) * RECIP_BITS'(RECIP_FIVE);
      return prod[RECIP_SHIFT +: CHAN_BITS];
   endfunction

endpackage
`default_nettype wire

>>> rtl/grhsv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv request / response interfaces
// Valid-ready channels of the color generator.
// ----------------------------------------------------------------------------
interface grhsv_req_if;
   logic valid;
   logic ready;
   logic dark_palette;

   modport source (output valid, output dark_palette, input ready);
   modport sink   (input valid, input dark_palette, output ready);
endinterface

interface grhsv_rsp_if;
   import grhsv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHAN_BITS-1:0]    red;
   logic [CHAN_BITS-1:0]    green;
   logic [CHAN_BITS-1:0]    blue;
   logic [HUE_OUT_BITS-1:0] hue_out;

   modport source (output valid, output red, output green, output blue, output hue_out,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input hue_out,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/grhsv_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv_csr
// APB register file: hue seed.
// ----------------------------------------------------------------------------
module grhsv_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [grhsv_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [grhsv_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [grhsv_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                       csr_pready,
   output logic      [grhsv_pkg::SEED_BITS-1:0]       hue_seed
);
   import grhsv_pkg::*;

   logic [SEED_BITS-1:0] hue_seed_ff;
   logic [SEED_BITS-1:0] hue_seed_in;
   logic                 wr_en;
   reg_index_type        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      hue_seed_in = hue_seed_ff;
      csr_prdata  = '0;
      unique case (reg_idx)
         REG_HUE_SEED: begin
            csr_prdata = CSR_DATA_BITS'(hue_seed_ff);
            if (wr_en) begin
               hue_seed_in = csr_pwdata[SEED_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_seed_ff <= '0;
      end else begin
         hue_seed_ff <= hue_seed_in;
      end
   end

   assign hue_seed = hue_seed_ff;

endmodule
`default_nettype wire

>>> rtl/grhsv_hue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv_hue
// Golden-step hue accumulator and input register.
// ----------------------------------------------------------------------------
module grhsv_hue #(
   parameter int HUE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [grhsv_pkg::SEED_BITS-1:0]   hue_seed,
   input  wire logic                              in_valid,
   input  wire logic                              in_dark,
   output logic                                   in_ready,
   output logic                                   out_valid,
   output logic      [HUE_BITS-1:0]               out_hue,
   output logic                                   out_dark,
   input  wire logic                              out_ready
);
   import grhsv_pkg::*;

   localparam logic [HUE_BITS-1:0] HUE_STEP = GOLD_FRAC64[63 -: HUE_BITS];

   logic [HUE_BITS-1:0] acc_ff, acc_in;
   logic [HUE_BITS-1:0] hue_ff, hue_in;
   logic                dark_ff;
   logic                vld_ff, vld_in;
   logic [HUE_BITS-1:0] seed_aligned;
   logic                take;

   // seed U0.16 -> U0.HUE_BITS
   if (HUE_BITS >= SEED_BITS) begin : g_seed_wide
      assign seed_aligned = HUE_BITS'({hue_seed, {(HUE_BITS - SEED_BITS + 1){1'b0}}} >> 1);
   end else begin : g_seed_narrow
      assign seed_aligned = hue_seed[SEED_BITS-1 -: HUE_BITS];
   end

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      acc_in = acc_ff;
      vld_in = vld_ff && !out_ready;
      if (take) begin
         acc_in = acc_ff + HUE_STEP;
         vld_in = 1'b1;
      end
      hue_in = seed_aligned + acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hue_ff  <= hue_in;
         dark_ff <= in_dark;
      end
   end

   assign out_valid = vld_ff;
   assign out_hue   = hue_ff;
   assign out_dark  = dark_ff;

endmodule
`default_nettype wire

>>> rtl/grhsv_sector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv_sector
// Splits the hue into sector and position, forms the q and t numerators.
// ----------------------------------------------------------------------------
module grhsv_sector #(
   parameter int HUE_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [HUE_BITS-1:0]         in_hue,
   input  wire logic                        in_dark,
   output logic                             in_ready,
   output logic                             out_valid,
   output grhsv_pkg::mid_stage_type         out_data,
   input  wire logic                        out_ready
);
   import grhsv_pkg::*;

   localparam int NW = HUE_BITS + MUL_BITS + 1;

   logic [HUE_BITS+2:0] prod6;
   logic [HUE_BITS-1:0] frac;
   logic [HUE_BITS:0]   x_q, x_t;
   logic [MUL_BITS-1:0] sat_mul;
   logic [NW-1:0]       bias;
   logic [NW-1:0]       cx_q, cx_t;
   logic [NW-1:0]       num_q, num_t;
   logic [HUE_OUT_BITS-1:0] hue_al;
   mid_stage_type       data_ff, data_in;
   logic                vld_ff, vld_in;
   logic                take;

   // hue * 6 by shift-add; top 3 bits pick the sector
   assign prod6 = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};
   assign frac  = prod6[HUE_BITS-1:0];
   assign x_q   = {1'b0, frac};
   assign x_t   = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, frac};

   assign sat_mul = in_dark ? SAT_MUL_DARK : SAT_MUL_LITE;
   assign bias    = {1'b0, NUM_BIAS, {HUE_BITS{1'b0}}};
   assign cx_q    = NW'(sat_mul) * NW'(x_q);
   assign cx_t    = NW'(sat_mul) * NW'(x_t);
   assign num_q   = bias - cx_q;
   assign num_t   = bias - cx_t;

   if (HUE_BITS >= HUE_OUT_BITS) begin : g_out_narrow
      assign hue_al = in_hue[HUE_BITS-1 -: HUE_OUT_BITS];
   end else begin : g_out_wide
      assign hue_al = HUE_OUT_BITS'({in_hue, {(HUE_OUT_BITS - HUE_BITS + 1){1'b0}}} >> 1);
   end

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      data_in.dark    = in_dark;
      data_in.sector  = hue_sector_type'(prod6[HUE_BITS+2:HUE_BITS]);
      data_in.y_q     = num_q[HUE_BITS+3 +: Y_BITS];
      data_in.y_t     = num_t[HUE_BITS+3 +: Y_BITS];
      data_in.hue_out = hue_al;
      vld_in          = take || (vld_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

>>> rtl/grhsv_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grhsv_scale
// Final divide by five, sector channel mapping and result register.
// ----------------------------------------------------------------------------
module grhsv_scale (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire grhsv_pkg::mid_stage_type              in_data,
   output logic                                       in_ready,
   output logic                                       out_valid,
   output logic      [grhsv_pkg::CHAN_BITS-1:0]       out_red,
   output logic      [grhsv_pkg::CHAN_BITS-1:0]       out_green,
   output logic      [grhsv_pkg::CHAN_BITS-1:0]       out_blue,
   output logic      [grhsv_pkg::HUE_OUT_BITS-1:0]    out_hue,
   input  wire logic                                  out_ready
);
   import grhsv_pkg::*;

   logic [CHAN_BITS-1:0]    ch_v, ch_p, ch_q, ch_t;
   logic [CHAN_BITS-1:0]    red_in, green_in, blue_in;
   logic [CHAN_BITS-1:0]    red_ff, green_ff, blue_ff;
   logic [HUE_OUT_BITS-1:0] hue_ff;
   logic                    vld_ff, vld_in;
   logic                    take;

   assign ch_v = CHAN_V;
   assign ch_p = in_data.dark ? CHAN_P_DARK : CHAN_P_LITE;
   assign ch_q = scale_chan(in_data.y_q);
   assign ch_t = scale_chan(in_data.y_t);

   always_comb begin
      case (in_data.sector)
         SECT_RED_YEL: begin
            red_in = ch_v; green_in = ch_t; blue_in = ch_p;
         end
         SECT_YEL_GRN: begin
            red_in = ch_q; green_in = ch_v; blue_in = ch_p;
         end
         SECT_GRN_CYN: begin
            red_in = ch_p; green_in = ch_v; blue_in = ch_t;
         end
         SECT_CYN_BLU: begin
            red_in = ch_p; green_in = ch_q; blue_in = ch_v;
         end
         SECT_BLU_MAG: begin
            red_in = ch_t; green_in = ch_p; blue_in = ch_v;
         end
         default: begin
            red_in = ch_v; green_in = ch_p; blue_in = ch_q;
         end
      endcase
   end

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign vld_in   = take || (vld_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         hue_ff   <= in_data.hue_out;
      end
   end

   assign out_valid = vld_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;
   assign out_hue   = hue_ff;

endmodule
`default_nettype wire

>>> rtl/golden_ratio_hsv_color_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// golden_ratio_hsv_color_generator
// Usage:
//   Each request transaction on req_chan carries a palette bit (light or
//   dark) and yields exactly one response transaction on rsp_chan with an
//   8-bit RGB color and the U0.16 hue it was made from. Successive hues are
//   spaced by the golden-ratio fraction of a turn, starting at hue_seed
//   plus one step; hue_seed is written over the APB csr_ port (address 0).
//   Throughput: one transaction per cycle while rsp_chan does not stall,
//   set by the three-stage pipeline (hue register, sector stage, result
//   register) that each accepted request passes through in turn.
//   Reset clears the hue accumulator, sets hue_seed to 0 and empties the
//   pipeline. When rsp_chan stalls, each stage holds its transaction; up to
//   three transactions are buffered before req_chan.ready drops.
// ----------------------------------------------------------------------------
module golden_ratio_hsv_color_generator #(
   parameter int HUE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [grhsv_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [grhsv_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [grhsv_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                       csr_pready,
   // channels
   grhsv_req_if.sink                                  req_chan,
   grhsv_rsp_if.source                                rsp_chan
);
   import grhsv_pkg::*;

   logic [SEED_BITS-1:0] hue_seed;

   // hue stage -> sector stage
   logic                 hue_vld, hue_rdy, hue_dark;
   logic [HUE_BITS-1:0]  hue_val;

   // sector stage -> scale stage
   logic                 mid_vld, mid_rdy;
   mid_stage_type        mid_data;

   grhsv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hue_seed    (hue_seed)
   );

   // Accumulator advances on accept; hue = seed + accumulated steps
   grhsv_hue #(.HUE_BITS(HUE_BITS)) u_hue (
      .clock     (clock),
      .reset     (reset),
      .hue_seed  (hue_seed),
      .in_valid  (req_chan.valid),
      .in_dark   (req_chan.dark_palette),
      .in_ready  (req_chan.ready),
      .out_valid (hue_vld),
      .out_hue   (hue_val),
      .out_dark  (hue_dark),
      .out_ready (hue_rdy)
   );

   // Sector split and q/t numerators (constant multiplies)
   grhsv_sector #(.HUE_BITS(HUE_BITS)) u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_vld),
      .in_hue    (hue_val),
      .in_dark   (hue_dark),
      .in_ready  (hue_rdy),
      .out_valid (mid_vld),
      .out_data  (mid_data),
      .out_ready (mid_rdy)
   );

   // Divide by five, map channels to RGB, result register
   grhsv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_vld),
      .in_data   (mid_data),
      .in_ready  (mid_rdy),
      .out_valid (rsp_chan.valid),
      .out_red   (rsp_chan.red),
      .out_green (rsp_chan.green),
      .out_blue  (rsp_chan.blue),
      .out_hue   (rsp_chan.hue_out),
      .out_ready (rsp_chan.ready)
   );

endmodule
`default_nettype wire
